// ----- rtl/tmedyuv_pkg.sv -----
// Shared types and constants for the temporal median YUV 4:2:0 filter.
// No dependencies; used by the interfaces and by the top level.
`default_nettype none

package tmedyuv_pkg;

   // Payload and configuration field widths
   localparam int PIXEL_W    = 8;
   localparam int DIM_W      = 7;
   localparam int WIN_CFG_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_WINDOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CB_WINDOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CR_WINDOW    = 3'd4;

   // Reset values of the configuration registers
   localparam logic [DIM_W-1:0]     RESET_DIM    = 7'd64;
   localparam logic [WIN_CFG_W-1:0] RESET_WINDOW = 4'd0;

   // Smallest legal frame dimension
   localparam logic [DIM_W-1:0] MIN_DIM = 7'd2;

   // Filler for unused sorter cells; never sorts before a real sample
   localparam logic [PIXEL_W-1:0] PAD_VALUE = 8'hFF;

   // Per-byte sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_SORT,
      ST_SHIFT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/tmedyuv_req_if.sv -----
// Input byte channel: valid/ready handshake carrying one stream byte.
// Depends on tmedyuv_pkg for the pixel width.
`default_nettype none

interface tmedyuv_req_if;
   logic                             valid;
   logic                             ready;
   logic [tmedyuv_pkg::PIXEL_W-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/tmedyuv_rsp_if.sv -----
// Result byte channel: valid/ready handshake carrying filtered byte and frame end.
// Depends on tmedyuv_pkg for the pixel width.
`default_nettype none

interface tmedyuv_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tmedyuv_pkg::PIXEL_W-1:0]  pixel_out;
   logic                             frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/tmedyuv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tmedyuv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/temporal_median_yuv420.sv -----
// Temporal median filter for a planar YUV 4:2:0 byte stream.
// Depends on tmedyuv_pkg, tmedyuv_req_if, tmedyuv_rsp_if and tmedyuv_ram.
//
//   channel   dir   handshake                 payload
//   req       in    req_if.valid/ready        pixel_in
//   rsp       out   rsp_if.valid/ready        pixel_out, frame_last
//   csr       in    csr_wr_en (no stall)      csr_index, csr_wr_data
//
// Pass-through: an accepted byte passes decide and emit, then loads the result register.
// Median over k frames: the byte passes decide, read, sort, shift and emit; one
// stored frame per cycle is read into an insertion sorter, then the sorted row is
// shifted down to the middle value or pair.
// req is ready only when idle; a finished byte waits in emit for the result
// register. Reset is synchronous; the frame store is not cleared (warm-up rewrites it).
`default_nettype none

module temporal_median_yuv420 #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WINDOW = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   tmedyuv_req_if.sink                          req_if,
   tmedyuv_rsp_if.source                        rsp_if,
   input  wire                                  csr_wr_en,
   input  wire [tmedyuv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [tmedyuv_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int PW          = tmedyuv_pkg::PIXEL_W;
   localparam int DW          = tmedyuv_pkg::DIM_W;
   localparam int CW          = tmedyuv_pkg::WIN_CFG_W;
   localparam int SLOT_BYTES  = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
   localparam int POS_W       = $clog2(SLOT_BYTES);
   localparam int LEN_W       = $clog2(SLOT_BYTES + 1) + 1;
   localparam int STORE_DEPTH = SLOT_BYTES * MAX_WINDOW;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SLOT_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
   localparam int ROW_N       = (MAX_WINDOW < 2) ? 2 : MAX_WINDOW;

   // Clamp a frame dimension into range and round it down to even
   function automatic logic [DW-1:0] dim_eff(input logic [DW-1:0] v, input int maxv);
      logic [DW-1:0] r;
      if (v < tmedyuv_pkg::MIN_DIM) begin
         r = tmedyuv_pkg::MIN_DIM;
      end else if (int'(v) > maxv) begin
         r = DW'(maxv);
      end else begin
         r = v;
      end
      return {r[DW-1:1], 1'b0};
   endfunction

   // Saturate a window size at the largest ring depth
   function automatic logic [WIN_W-1:0] win_eff(input logic [CW-1:0] v);
      logic [WIN_W-1:0] r;
      if (int'(v) > MAX_WINDOW) begin
         r = WIN_W'(MAX_WINDOW);
      end else begin
         r = WIN_W'(v);
      end
      return r;
   endfunction

   // Configuration registers
   logic [DW-1:0] width_ff, height_ff;
   logic [CW-1:0] yw_cfg_ff, uw_cfg_ff, vw_cfg_ff;
   logic          cfg_hit;

   // Stream position and sequencer state
   tmedyuv_pkg::state_type state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WIN_W-1:0]  seen_ff, seen_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [WIN_W-1:0]  cnt_ff, cnt_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [PW-1:0]     byte_ff, byte_in;
   logic [PW-1:0]     med_ff, med_in;
   logic              last_ff, last_in;
   logic [PW-1:0]     row_ff [ROW_N];
   logic [PW-1:0]     row_in [ROW_N];
   logic [PW-1:0]     ins_row [ROW_N];

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] res_ff, res_in;
   logic          last_out_ff, last_out_in;

   // Derived frame geometry
   logic [DW-1:0]    w_eff, h_eff;
   logic [WIN_W-1:0] yw, uw, vw, ring;
   logic [LEN_W-1:0] luma_len_ff;
   logic [LEN_W-1:0] u_end, frame_len;
   logic [WIN_W-1:0] sel_win;
   logic             is_last, need_med;
   logic [PW:0]      pair_sum;

   // Frame store ports
   logic              accept;
   logic              rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [PW-1:0]     rd_data;

   // Configuration writes; any known index restarts the stream
   assign cfg_hit = csr_wr_en && (csr_index <= tmedyuv_pkg::CSR_CR_WINDOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tmedyuv_pkg::RESET_DIM;
         height_ff <= tmedyuv_pkg::RESET_DIM;
         yw_cfg_ff <= tmedyuv_pkg::RESET_WINDOW;
         uw_cfg_ff <= tmedyuv_pkg::RESET_WINDOW;
         vw_cfg_ff <= tmedyuv_pkg::RESET_WINDOW;
      end else if (csr_wr_en) begin
         case (csr_index)
            tmedyuv_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wr_data[DW-1:0];
            tmedyuv_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wr_data[DW-1:0];
            tmedyuv_pkg::CSR_LUMA_WINDOW:  yw_cfg_ff <= csr_wr_data[CW-1:0];
            tmedyuv_pkg::CSR_CB_WINDOW:    uw_cfg_ff <= csr_wr_data[CW-1:0];
            tmedyuv_pkg::CSR_CR_WINDOW:    vw_cfg_ff <= csr_wr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry and ring depth
   always_comb begin
      w_eff = dim_eff(width_ff, MAX_WIDTH);
      h_eff = dim_eff(height_ff, MAX_HEIGHT);
      yw    = win_eff(yw_cfg_ff);
      uw    = win_eff(uw_cfg_ff);
      vw    = win_eff(vw_cfg_ff);
      ring  = yw;
      if (uw > ring) begin
         ring = uw;
      end
      if (vw > ring) begin
         ring = vw;
      end
      if (ring == '0) begin
         ring = WIN_W'(1);
      end
   end

   // Luma plane size, registered after the multiply
   always_ff @(posedge clock) begin
      luma_len_ff <= LEN_W'(w_eff * h_eff);
   end

   // Chroma plane ends; luma size is a multiple of four
   assign u_end     = luma_len_ff + (luma_len_ff >> 2);
   assign frame_len = luma_len_ff + (luma_len_ff >> 1);

   // Classification of the byte in flight
   always_comb begin
      if (LEN_W'(pos_ff) < luma_len_ff) begin
         sel_win = yw;
      end else if (LEN_W'(pos_ff) < u_end) begin
         sel_win = uw;
      end else begin
         sel_win = vw;
      end
      is_last  = (LEN_W'(pos_ff) == (frame_len - LEN_W'(1)));
      need_med = (seen_ff >= ring) && (sel_win > WIN_W'(1));
   end

   // Insertion of the returning sample into the ascending row
   always_comb begin
      ins_row[0] = (row_ff[0] <= rd_data) ? row_ff[0] : rd_data;
      for (int j = 1; j < ROW_N; j++) begin
         if (row_ff[j] <= rd_data) begin
            ins_row[j] = row_ff[j];
         end else if (row_ff[j-1] > rd_data) begin
            ins_row[j] = row_ff[j-1];
         end else begin
            ins_row[j] = rd_data;
         end
      end
   end

   assign pair_sum = {1'b0, row_ff[0]} + {1'b0, row_ff[1]};

   // Frame store addressing
   assign accept  = req_if.valid && (state_ff == tmedyuv_pkg::ST_IDLE);
   assign wr_addr = ADDR_W'(slot_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos_ff);
   assign rd_addr = ADDR_W'(rd_slot_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos_ff);

   tmedyuv_ram #(
      .WIDTH (PW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_if.pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      seen_in      = seen_ff;
      rd_slot_in   = rd_slot_ff;
      cnt_in       = cnt_ff;
      win_in       = win_ff;
      byte_in      = byte_ff;
      med_in       = med_ff;
      last_in      = last_ff;
      row_in       = row_ff;
      rd_en        = 1'b0;
      rd_valid_in  = (state_ff == tmedyuv_pkg::ST_READ);
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      res_in       = res_ff;
      last_out_in  = last_out_ff;

      case (state_ff)
         tmedyuv_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               byte_in  = req_if.pixel_in;
               state_in = tmedyuv_pkg::ST_DECIDE;
            end
         end
         tmedyuv_pkg::ST_DECIDE: begin
            last_in = is_last;
            if (need_med) begin
               win_in     = sel_win;
               cnt_in     = '0;
               rd_slot_in = slot_ff;
               for (int j = 0; j < ROW_N; j++) begin
                  row_in[j] = tmedyuv_pkg::PAD_VALUE;
               end
               state_in = tmedyuv_pkg::ST_READ;
            end else begin
               med_in   = byte_ff;
               state_in = tmedyuv_pkg::ST_EMIT;
            end
         end
         tmedyuv_pkg::ST_READ: begin
            // newest frame first, walking back around the ring
            rd_en = 1'b1;
            if (rd_slot_ff == '0) begin
               rd_slot_in = SLOT_W'(ring - WIN_W'(1));
            end else begin
               rd_slot_in = rd_slot_ff - SLOT_W'(1);
            end
            cnt_in = cnt_ff + WIN_W'(1);
            if (cnt_ff == win_ff - WIN_W'(1)) begin
               state_in = tmedyuv_pkg::ST_SORT;
            end
         end
         tmedyuv_pkg::ST_SORT: begin
            cnt_in   = '0;
            state_in = tmedyuv_pkg::ST_SHIFT;
         end
         tmedyuv_pkg::ST_SHIFT: begin
            // drop the low half until the middle value sits in cell zero
            if (cnt_ff == ((win_ff - WIN_W'(1)) >> 1)) begin
               if (win_ff[0]) begin
                  med_in = row_ff[0];
               end else begin
                  med_in = pair_sum[PW:1];
               end
               state_in = tmedyuv_pkg::ST_EMIT;
            end else begin
               for (int j = 0; j < ROW_N - 1; j++) begin
                  row_in[j] = row_ff[j+1];
               end
               row_in[ROW_N-1] = tmedyuv_pkg::PAD_VALUE;
               cnt_in = cnt_ff + WIN_W'(1);
            end
         end
         tmedyuv_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               res_in       = med_ff;
               last_out_in  = last_ff;
               if (last_ff) begin
                  pos_in = '0;
                  if (seen_ff < ring) begin
                     seen_in = seen_ff + WIN_W'(1);
                  end
                  if (WIN_W'(slot_ff) + WIN_W'(1) == ring) begin
                     slot_in = '0;
                  end else begin
                     slot_in = slot_ff + SLOT_W'(1);
                  end
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = tmedyuv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmedyuv_pkg::ST_IDLE;
         end
      endcase

      // sample fetched last cycle joins the sorted row
      if (rd_valid_ff) begin
         row_in = ins_row;
      end

      // configuration restarts the stream and its warm-up
      if (cfg_hit) begin
         pos_in  = '0;
         slot_in = '0;
         seen_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmedyuv_pkg::ST_IDLE;
         pos_ff       <= '0;
         slot_ff      <= '0;
         seen_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         seen_ff      <= seen_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_slot_ff  <= rd_slot_in;
      cnt_ff      <= cnt_in;
      win_ff      <= win_in;
      byte_ff     <= byte_in;
      med_ff      <= med_in;
      last_ff     <= last_in;
      row_ff      <= row_in;
      res_ff      <= res_in;
      last_out_ff <= last_out_in;
   end

   assign req_if.ready      = (state_ff == tmedyuv_pkg::ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_out  = res_ff;
   assign rsp_if.frame_last = last_out_ff;

`ifndef SYNTHESIS
   // write slot always lies inside the ring
   assert property (@(posedge clock) disable iff (reset)
      WIN_W'(slot_ff) < ring)
      else $error("write slot outside ring");

   // frame count saturates at the ring depth
   assert property (@(posedge clock) disable iff (reset)
      seen_ff <= ring)
      else $error("frames seen beyond ring depth");

   // a median fetch only runs for windows of two or more
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmedyuv_pkg::ST_READ) |-> (win_ff > WIN_W'(1)))
      else $error("fetch with window below two");

   // a new result only comes from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tmedyuv_pkg::ST_EMIT))
      else $error("result raised outside emit");
`endif

endmodule

`default_nettype wire

// ----- test/temporal_median_yuv420_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for temporal_median_yuv420: streams 4:2:0 bytes under
// several register settings and idle patterns, compares every filtered byte.
// Depends on tmedyuv_pkg, tmedyuv_req_if, tmedyuv_rsp_if and the RTL top level.

module temporal_median_yuv420_test;

   localparam int MAX_WIDTH     = 64;
   localparam int MAX_HEIGHT    = 64;
   localparam int MAX_WINDOW    = 8;
   localparam int SLOT_BYTES    = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 10;
   localparam int PHASE_ITEMS   = 60;
   localparam int CSR_DATA_MAX  = (1 << tmedyuv_pkg::CSR_DATA_W) - 1;

   typedef logic [tmedyuv_pkg::PIXEL_W-1:0]    pixel_type;
   typedef logic [tmedyuv_pkg::CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [tmedyuv_pkg::CSR_DATA_W-1:0] csr_data_type;
   typedef logic [tmedyuv_pkg::DIM_W-1:0]      dim_type;
   typedef logic [tmedyuv_pkg::WIN_CFG_W-1:0]  window_type;
   typedef struct packed {
      pixel_type pixel;
      logic      last;
   } filtered_byte_type;

   localparam csr_index_type CSR_FIRST_UNUSED = csr_index_type'(tmedyuv_pkg::CSR_CR_WINDOW + 1);
   localparam csr_index_type CSR_LAST_INDEX   = '1;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   csr_data_type  csr_wr_data;

   tmedyuv_req_if req_ch ();
   tmedyuv_rsp_if rsp_ch ();

   temporal_median_yuv420 #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WINDOW (MAX_WINDOW)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shared bench state
   filtered_byte_type expected_bytes[$];
   int errors        = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asks     = 0;

   // Predictor copy of registers and frame history
   dim_type    width_reg;
   dim_type    height_reg;
   window_type luma_win_reg;
   window_type cb_win_reg;
   window_type cr_win_reg;
   pixel_type  history [0:MAX_WINDOW*SLOT_BYTES-1];
   int         hist_pos;
   int         hist_slot;
   int         frames_done;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Dimension as the block sees it: clamped, then rounded down to even
   function automatic int clamp_dim(input dim_type raw, input int max_dim);
      int d;
      d = raw;
      if (d < 2) d = 2;
      if (d > max_dim) d = max_dim;
      return d & ~1;
   endfunction

   function automatic int clamp_window(input window_type raw);
      return (raw > MAX_WINDOW) ? MAX_WINDOW : int'(raw);
   endfunction

   // Number of slots in the history ring
   function automatic int ring_depth();
      int r;
      r = clamp_window(luma_win_reg);
      if (clamp_window(cb_win_reg) > r) r = clamp_window(cb_win_reg);
      if (clamp_window(cr_win_reg) > r) r = clamp_window(cr_win_reg);
      if (r < 1) r = 1;
      return r;
   endfunction

   function automatic int frame_bytes();
      return clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT) * 3 / 2;
   endfunction

   // Median of one position over the newest k slots; even k gives floored mean
   function automatic pixel_type temporal_median(input int pos, input int k, input int ring);
      pixel_type v [MAX_WINDOW];
      pixel_type t;
      int        s;
      int        j;
      for (int i = 0; i < k; i++) begin
         s = (hist_slot >= i) ? hist_slot - i : hist_slot + ring - i;
         v[i] = history[s*SLOT_BYTES + pos];
      end
      for (int i = 1; i < k; i++) begin
         t = v[i];
         j = i;
         while (j > 0 && v[j-1] > t) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = t;
      end
      if (k % 2 == 0) return pixel_type'((int'(v[k/2]) + int'(v[k/2-1])) / 2);
      return v[k/2];
   endfunction

   // Store one byte, work out its filtered value and advance the stream
   function automatic filtered_byte_type predict_filtered_byte(input pixel_type b);
      int                yw, uw, vw, ring, luma_len, u_end, frame_len, pos, win;
      filtered_byte_type r;
      yw = clamp_window(luma_win_reg);
      uw = clamp_window(cb_win_reg);
      vw = clamp_window(cr_win_reg);
      ring = ring_depth();
      luma_len = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
      u_end = luma_len * 5 / 4;
      frame_len = luma_len * 3 / 2;
      if (hist_slot >= ring) hist_slot = 0;
      if (hist_pos >= frame_len) hist_pos = 0;
      pos = hist_pos;
      history[hist_slot*SLOT_BYTES + pos] = b;
      r.pixel = b;
      if (frames_done >= ring) begin
         win = (pos < luma_len) ? yw : (pos < u_end) ? uw : vw;
         if (win > 1) r.pixel = temporal_median(pos, win, ring);
      end
      r.last = (pos == frame_len - 1);
      if (r.last) begin
         hist_pos = 0;
         if (frames_done < ring) frames_done++;
         hist_slot = (hist_slot + 1 == ring) ? 0 : hist_slot + 1;
      end else begin
         hist_pos = pos + 1;
      end
      return r;
   endfunction

   // Register write; known indexes restart the stream
   function automatic void apply_csr(input csr_index_type idx, input csr_data_type data);
      case (idx)
         tmedyuv_pkg::CSR_FRAME_WIDTH:  width_reg = data[tmedyuv_pkg::DIM_W-1:0];
         tmedyuv_pkg::CSR_FRAME_HEIGHT: height_reg = data[tmedyuv_pkg::DIM_W-1:0];
         tmedyuv_pkg::CSR_LUMA_WINDOW:  luma_win_reg = data[tmedyuv_pkg::WIN_CFG_W-1:0];
         tmedyuv_pkg::CSR_CB_WINDOW:    cb_win_reg = data[tmedyuv_pkg::WIN_CFG_W-1:0];
         tmedyuv_pkg::CSR_CR_WINDOW:    cr_win_reg = data[tmedyuv_pkg::WIN_CFG_W-1:0];
         default:                       return;
      endcase
      hist_pos = 0;
      hist_slot = 0;
      frames_done = 0;
   endfunction

   // Bytes lean toward the top of the range to stress the mean of the middle pair
   function automatic pixel_type random_pixel();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         2:       return pixel_type'($urandom_range(250, 255));
         default: return pixel_type'($urandom());
      endcase
   endfunction

   // Mostly legal windows, sometimes the whole 7-bit data range
   function automatic csr_data_type random_window_raw();
      if ($urandom_range(99) < 25) return csr_data_type'($urandom_range(0, CSR_DATA_MAX));
      return csr_data_type'($urandom_range(0, MAX_WINDOW + 1));
   endfunction

   function automatic csr_index_type random_unused_index();
      return csr_index_type'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX));
   endfunction

   // One request; starts and ends at a falling edge
   task automatic send_pixel(input pixel_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel_in <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_bytes.push_back(predict_filtered_byte(b));
      @(negedge clock);
   endtask

   // Stop requests and let every result come back, then let the bench settle
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input csr_data_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      apply_csr(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random(input int n);
      repeat (n) send_pixel(random_pixel());
   endtask

   // Pass-through at the reset settings (64x64, all windows off)
   task automatic test_reset_defaults();
      pixel_type pattern [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      foreach (pattern[i]) send_pixel(pattern[i]);
   endtask

   // Out-of-range dims fall to 2x2; two frames of warm-up, then one of medians
   task automatic test_warmup_and_median();
      pixel_type pattern [18] = '{
         8'hFF, 8'hFF, 8'h00, 8'h0A, 8'h07, 8'hC8,
         8'hFF, 8'hFE, 8'h00, 8'h14, 8'h09, 8'h64,
         8'hFF, 8'hFF, 8'h01, 8'h1F, 8'h08, 8'h00};
      drain_results();
      write_csr(tmedyuv_pkg::CSR_FRAME_WIDTH, 7'd1);
      write_csr(tmedyuv_pkg::CSR_FRAME_HEIGHT, 7'd0);
      write_csr(tmedyuv_pkg::CSR_LUMA_WINDOW, 7'd2);
      write_csr(tmedyuv_pkg::CSR_CB_WINDOW, 7'd1);
      write_csr(tmedyuv_pkg::CSR_CR_WINDOW, 7'd2);
      foreach (pattern[i]) send_pixel(pattern[i]);
   endtask

   // Widest frame: width above range clamps to 64, odd height rounds down
   task automatic test_wide_frame();
      drain_results();
      write_csr(tmedyuv_pkg::CSR_FRAME_WIDTH, 7'd65);
      write_csr(tmedyuv_pkg::CSR_FRAME_HEIGHT, 7'd3);
      write_csr(tmedyuv_pkg::CSR_LUMA_WINDOW, 7'd1);
      write_csr(tmedyuv_pkg::CSR_CB_WINDOW, 7'h10);
      write_csr(tmedyuv_pkg::CSR_CR_WINDOW, 7'h71);
      send_random(100);
   endtask

   // Tallest frame
   task automatic test_tall_frame();
      drain_results();
      write_csr(tmedyuv_pkg::CSR_FRAME_WIDTH, 7'd2);
      write_csr(tmedyuv_pkg::CSR_FRAME_HEIGHT, '1);
      write_csr(tmedyuv_pkg::CSR_LUMA_WINDOW, 7'd0);
      write_csr(tmedyuv_pkg::CSR_CB_WINDOW, 7'h01);
      write_csr(tmedyuv_pkg::CSR_CR_WINDOW, 7'h60);
      send_random(100);
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_receiver_hold();
      drain_results();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_csr(tmedyuv_pkg::CSR_FRAME_WIDTH, 7'd2);
      write_csr(tmedyuv_pkg::CSR_FRAME_HEIGHT, 7'd2);
      write_csr(tmedyuv_pkg::CSR_LUMA_WINDOW, 7'd3);
      write_csr(tmedyuv_pkg::CSR_CB_WINDOW, 7'd1);
      write_csr(tmedyuv_pkg::CSR_CR_WINDOW, 7'd2);
      hold_asks++;
      send_random(40);
   endtask

   // New settings (or an ignored write), then a few frames and a partial one
   task automatic run_random_segment(input bit write_all, output int sent);
      int flen;
      int ring;
      drain_results();
      if (!write_all && $urandom_range(99) < 15) begin
         // unknown index: stream must carry on where it was
         write_csr(random_unused_index(), csr_data_type'($urandom_range(0, CSR_DATA_MAX)));
      end else begin
         if ($urandom_range(99) < 20)
            write_csr(random_unused_index(), csr_data_type'($urandom_range(0, CSR_DATA_MAX)));
         if (write_all || $urandom_range(99) < 60)
            write_csr(tmedyuv_pkg::CSR_LUMA_WINDOW, random_window_raw());
         if (write_all || $urandom_range(99) < 60)
            write_csr(tmedyuv_pkg::CSR_CB_WINDOW, random_window_raw());
         if (write_all || $urandom_range(99) < 60)
            write_csr(tmedyuv_pkg::CSR_CR_WINDOW, random_window_raw());
         // deep rings get the smallest frame to keep warm-up short
         if (ring_depth() > 4) begin
            write_csr(tmedyuv_pkg::CSR_FRAME_WIDTH, csr_data_type'($urandom_range(0, 3)));
            write_csr(tmedyuv_pkg::CSR_FRAME_HEIGHT, csr_data_type'($urandom_range(0, 3)));
         end else begin
            if (write_all || $urandom_range(99) < 60)
               write_csr(tmedyuv_pkg::CSR_FRAME_WIDTH, csr_data_type'($urandom_range(0, 5)));
            if (write_all || $urandom_range(99) < 60)
               write_csr(tmedyuv_pkg::CSR_FRAME_HEIGHT, csr_data_type'($urandom_range(0, 5)));
         end
      end
      flen = frame_bytes();
      ring = ring_depth();
      sent = flen * (ring + $urandom_range(1, 2)) + $urandom_range(0, flen - 1);
      send_random(sent);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct);
      int  done;
      int  sent;
      bit  first;
      drain_results();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      done = 0;
      first = 1'b1;
      while (done < PHASE_ITEMS) begin
         run_random_segment(first, sent);
         first = 1'b0;
         done += sent;
      end
   endtask

   // Result receiver: random stalls plus long hold-offs on request
   initial begin : result_sink
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      filtered_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected result: pixel %0d last %0b",
                        rsp_ch.pixel_out, rsp_ch.frame_last);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_ch.pixel_out !== want.pixel || rsp_ch.frame_last !== want.last) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                           want.pixel, rsp_ch.pixel_out, want.last, rsp_ch.frame_last);
            end
         end
      end
   end

   // Run limit
   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : main_sequence
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel_in = '0;
      width_reg = tmedyuv_pkg::RESET_DIM;
      height_reg = tmedyuv_pkg::RESET_DIM;
      luma_win_reg = tmedyuv_pkg::RESET_WINDOW;
      cb_win_reg = tmedyuv_pkg::RESET_WINDOW;
      cr_win_reg = tmedyuv_pkg::RESET_WINDOW;
      foreach (history[i]) history[i] = 8'd127;
      hist_pos = 0;
      hist_slot = 0;
      frames_done = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_warmup_and_median();
      test_wide_frame();
      test_tall_frame();
      test_receiver_hold();
      test_random_phase(0, 0);
      test_random_phase(70, 0);
      test_random_phase(0, 70);
      test_random_phase(16, 16);

      drain_results();
      if (expected_bytes.size() != 0) errors++;
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
